@@ sv/aes_pkg.sv @@
// aes-128 package: sbox table, round constants, byte helpers
// no dependencies
`default_nettype none
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int CsrIdxW = 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_idx_type;

   typedef logic [127:0] block_type;
   typedef logic [31:0] col_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] y;
      case (x)
         8'h00: y=8'h63; 8'h01: y=8'h7c; 8'h02: y=8'h77; 8'h03: y=8'h7b;
         8'h04: y=8'hf2; 8'h05: y=8'h6b; 8'h06: y=8'h6f; 8'h07: y=8'hc5;
         8'h08: y=8'h30; 8'h09: y=8'h01; 8'h0a: y=8'h67; 8'h0b: y=8'h2b;
         8'h0c: y=8'hfe; 8'h0d: y=8'hd7; 8'h0e: y=8'hab; 8'h0f: y=8'h76;
         8'h10: y=8'hca; 8'h11: y=8'h82; 8'h12: y=8'hc9; 8'h13: y=8'h7d;
         8'h14: y=8'hfa; 8'h15: y=8'h59; 8'h16: y=8'h47; 8'h17: y=8'hf0;
         8'h18: y=8'had; 8'h19: y=8'hd4; 8'h1a: y=8'ha2; 8'h1b: y=8'haf;
         8'h1c: y=8'h9c; 8'h1d: y=8'ha4; 8'h1e: y=8'h72; 8'h1f: y=8'hc0;
         8'h20: y=8'hb7; 8'h21: y=8'hfd; 8'h22: y=8'h93; 8'h23: y=8'h26;
         8'h24: y=8'h36; 8'h25: y=8'h3f; 8'h26: y=8'hf7; 8'h27: y=8'hcc;
         8'h28: y=8'h34; 8'h29: y=8'ha5; 8'h2a: y=8'he5; 8'h2b: y=8'hf1;
         8'h2c: y=8'h71; 8'h2d: y=8'hd8; 8'h2e: y=8'h31; 8'h2f: y=8'h15;
         8'h30: y=8'h04; 8'h31: y=8'hc7; 8'h32: y=8'h23; 8'h33: y=8'hc3;
         8'h34: y=8'h18; 8'h35: y=8'h96; 8'h36: y=8'h05; 8'h37: y=8'h9a;
         8'h38: y=8'h07; 8'h39: y=8'h12; 8'h3a: y=8'h80; 8'h3b: y=8'he2;
         8'h3c: y=8'heb; 8'h3d: y=8'h27; 8'h3e: y=8'hb2; 8'h3f: y=8'h75;
         8'h40: y=8'h09; 8'h41: y=8'h83; 8'h42: y=8'h2c; 8'h43: y=8'h1a;
         8'h44: y=8'h1b; 8'h45: y=8'h6e; 8'h46: y=8'h5a; 8'h47: y=8'ha0;
         8'h48: y=8'h52; 8'h49: y=8'h3b; 8'h4a: y=8'hd6; 8'h4b: y=8'hb3;
         8'h4c: y=8'h29; 8'h4d: y=8'he3; 8'h4e: y=8'h2f; 8'h4f: y=8'h84;
         8'h50: y=8'h53; 8'h51: y=8'hd1; 8'h52: y=8'h00; 8'h53: y=8'hed;
         8'h54: y=8'h20; 8'h55: y=8'hfc; 8'h56: y=8'hb1; 8'h57: y=8'h5b;
         8'h58: y=8'h6a; 8'h59: y=8'hcb; 8'h5a: y=8'hbe; 8'h5b: y=8'h39;
         8'h5c: y=8'h4a; 8'h5d: y=8'h4c; 8'h5e: y=8'h58; 8'h5f: y=8'hcf;
         8'h60: y=8'hd0; 8'h61: y=8'hef; 8'h62: y=8'haa; 8'h63: y=8'hfb;
         8'h64: y=8'h43; 8'h65: y=8'h4d; 8'h66: y=8'h33; 8'h67: y=8'h85;
         8'h68: y=8'h45; 8'h69: y=8'hf9; 8'h6a: y=8'h02; 8'h6b: y=8'h7f;
         8'h6c: y=8'h50; 8'h6d: y=8'h3c; 8'h6e: y=8'h9f; 8'h6f: y=8'ha8;
         8'h70: y=8'h51; 8'h71: y=8'ha3; 8'h72: y=8'h40; 8'h73: y=8'h8f;
         8'h74: y=8'h92; 8'h75: y=8'h9d; 8'h76: y=8'h38; 8'h77: y=8'hf5;
         8'h78: y=8'hbc; 8'h79: y=8'hb6; 8'h7a: y=8'hda; 8'h7b: y=8'h21;
         8'h7c: y=8'h10; 8'h7d: y=8'hff; 8'h7e: y=8'hf3; 8'h7f: y=8'hd2;
         8'h80: y=8'hcd; 8'h81: y=8'h0c; 8'h82: y=8'h13; 8'h83: y=8'hec;
         8'h84: y=8'h5f; 8'h85: y=8'h97; 8'h86: y=8'h44; 8'h87: y=8'h17;
         8'h88: y=8'hc4; 8'h89: y=8'ha7; 8'h8a: y=8'h7e; 8'h8b: y=8'h3d;
         8'h8c: y=8'h64; 8'h8d: y=8'h5d; 8'h8e: y=8'h19; 8'h8f: y=8'h73;
         8'h90: y=8'h60; 8'h91: y=8'h81; 8'h92: y=8'h4f; 8'h93: y=8'hdc;
         8'h94: y=8'h22; 8'h95: y=8'h2a; 8'h96: y=8'h90; 8'h97: y=8'h88;
         8'h98: y=8'h46; 8'h99: y=8'hee; 8'h9a: y=8'hb8; 8'h9b: y=8'h14;
         8'h9c: y=8'hde; 8'h9d: y=8'h5e; 8'h9e: y=8'h0b; 8'h9f: y=8'hdb;
         8'ha0: y=8'he0; 8'ha1: y=8'h32; 8'ha2: y=8'h3a; 8'ha3: y=8'h0a;
         8'ha4: y=8'h49; 8'ha5: y=8'h06; 8'ha6: y=8'h24; 8'ha7: y=8'h5c;
         8'ha8: y=8'hc2; 8'ha9: y=8'hd3; 8'haa: y=8'hac; 8'hab: y=8'h62;
         8'hac: y=8'h91; 8'had: y=8'h95; 8'hae: y=8'he4; 8'haf: y=8'h79;
         8'hb0: y=8'he7; 8'hb1: y=8'hc8; 8'hb2: y=8'h37; 8'hb3: y=8'h6d;
         8'hb4: y=8'h8d; 8'hb5: y=8'hd5; 8'hb6: y=8'h4e; 8'hb7: y=8'ha9;
         8'hb8: y=8'h6c; 8'hb9: y=8'h56; 8'hba: y=8'hf4; 8'hbb: y=8'hea;
         8'hbc: y=8'h65; 8'hbd: y=8'h7a; 8'hbe: y=8'hae; 8'hbf: y=8'h08;
         8'hc0: y=8'hba; 8'hc1: y=8'h78; 8'hc2: y=8'h25; 8'hc3: y=8'h2e;
         8'hc4: y=8'h1c; 8'hc5: y=8'ha6; 8'hc6: y=8'hb4; 8'hc7: y=8'hc6;
         8'hc8: y=8'he8; 8'hc9: y=8'hdd; 8'hca: y=8'h74; 8'hcb: y=8'h1f;
         8'hcc: y=8'h4b; 8'hcd: y=8'hbd; 8'hce: y=8'h8b; 8'hcf: y=8'h8a;
         8'hd0: y=8'h70; 8'hd1: y=8'h3e; 8'hd2: y=8'hb5; 8'hd3: y=8'h66;
         8'hd4: y=8'h48; 8'hd5: y=8'h03; 8'hd6: y=8'hf6; 8'hd7: y=8'h0e;
         8'hd8: y=8'h61; 8'hd9: y=8'h35; 8'hda: y=8'h57; 8'hdb: y=8'hb9;
         8'hdc: y=8'h86; 8'hdd: y=8'hc1; 8'hde: y=8'h1d; 8'hdf: y=8'h9e;
         8'he0: y=8'he1; 8'he1: y=8'hf8; 8'he2: y=8'h98; 8'he3: y=8'h11;
         8'he4: y=8'h69; 8'he5: y=8'hd9; 8'he6: y=8'h8e; 8'he7: y=8'h94;
         8'he8: y=8'h9b; 8'he9: y=8'h1e; 8'hea: y=8'h87; 8'heb: y=8'he9;
         8'hec: y=8'hce; 8'hed: y=8'h55; 8'hee: y=8'h28; 8'hef: y=8'hdf;
         8'hf0: y=8'h8c; 8'hf1: y=8'ha1; 8'hf2: y=8'h89; 8'hf3: y=8'h0d;
         8'hf4: y=8'hbf; 8'hf5: y=8'he6; 8'hf6: y=8'h42; 8'hf7: y=8'h68;
         8'hf8: y=8'h41; 8'hf9: y=8'h99; 8'hfa: y=8'h2d; 8'hfb: y=8'h0f;
         8'hfc: y=8'hb0; 8'hfd: y=8'h54; 8'hfe: y=8'hbb; 8'hff: y=8'h16;
         default: y = 8'h00;
      endcase
      return y;
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] y;
      case (r)
         4'd1: y = 8'h01; 4'd2: y = 8'h02; 4'd3: y = 8'h04; 4'd4: y = 8'h08;
         4'd5: y = 8'h10; 4'd6: y = 8'h20; 4'd7: y = 8'h40; 4'd8: y = 8'h80;
         4'd9: y = 8'h1b; 4'd10: y = 8'h36;
         default: y = 8'h00;
      endcase
      return y;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block, byte 0 at the top
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127-8*i -: 8];
   endfunction

   // next round key from the previous one
   function automatic block_type next_key(input block_type k, input logic [3:0] r);
      col_type w0, w1, w2, w3, t;
      t  = {sbox(k[23:16]) ^ rcon(r), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

@@ sv/aes_lane.sv @@
// aes-128 column lane: sub bytes of a shifted column, mix if mix_i is set, add round key
// depends on aes_pkg
`default_nettype none
module aes_lane (
   input  wire aes_pkg::col_type col_i,   // already shift-row selected bytes
   input  wire aes_pkg::col_type key_i,
   input  wire                   mix_i,
   output aes_pkg::col_type      col_o
);
   import aes_pkg::*;

   logic [7:0] s0, s1, s2, s3, all;
   col_type mixed;

   // sub bytes
   assign s0 = sbox(col_i[31:24]);
   assign s1 = sbox(col_i[23:16]);
   assign s2 = sbox(col_i[15:8]);
   assign s3 = sbox(col_i[7:0]);

   // mix column
   assign all = s0 ^ s1 ^ s2 ^ s3;
   assign mixed = {s0 ^ all ^ xtime(s0 ^ s1), s1 ^ all ^ xtime(s1 ^ s2),
                   s2 ^ all ^ xtime(s2 ^ s3), s3 ^ all ^ xtime(s3 ^ s0)};

   assign col_o = (mix_i ? mixed : {s0, s1, s2, s3}) ^ key_i;
endmodule
`default_nettype wire

@@ sv/aes_round.sv @@
// one registered aes round: four column lanes merged into the next state
// depends on aes_pkg, aes_lane
`default_nettype none
module aes_round (
   input  wire                     clock,
   input  wire                     enable,
   input  wire                     mix_i,
   input  wire aes_pkg::block_type state_i,
   input  wire aes_pkg::block_type key_i,
   output aes_pkg::block_type      state_o
);
   import aes_pkg::*;

   block_type merged;
   block_type state_ff;

   // four lanes, each reads its diagonal after shift rows
   for (genvar c = 0; c < 4; c++) begin : g_lane
      col_type sh;
      assign sh = {get_byte(state_i, 4*c),
                   get_byte(state_i, 1 + 4*((c+1)%4)),
                   get_byte(state_i, 2 + 4*((c+2)%4)),
                   get_byte(state_i, 3 + 4*((c+3)%4))};
      aes_lane u_lane (
         .col_i (sh),
         .key_i (key_i[127-32*c -: 32]),
         .mix_i (mix_i),
         .col_o (merged[127-32*c -: 32])
      );
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= merged;
      end
   end
   assign state_o = state_ff;
endmodule
`default_nettype wire

@@ sv/aes128_block_encrypt.sv @@
// aes-128 ecb encrypt top: key registers, schedule, unrolled round pipeline
// depends on aes_pkg, aes_round
`default_nettype none
// One 128-bit word enters per clock while the pipeline advances. Its ciphertext
// passes eleven registers in a row, the initial key add loaded at the edge that
// accepts it and then ten registered rounds. The whole
// pipeline advances together whenever the output stage is free or being taken,
// so throughput is one word per cycle; a stalled output holds every stage.
// Round keys 1 to 10 are expanded in a register chain that runs one stage ahead
// of the data, so the first word accepted after a key write already uses the
// new key. Write the key only while the pipeline is empty.
module aes128_block_encrypt (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [0:0]  csr_index,
   input  wire [63:0] csr_data,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [63:0] req_plain_high,
   input  wire [63:0] req_plain_low,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   block_type   rk_ff [1:NumRounds];
   logic [NumRounds:0] vld_ff;
   block_type   st0_ff;
   block_type   st [NumRounds+1];
   logic        adv;

   assign csr_ready = 1'b1;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // round key chain, one expansion step per register; it is not held by a stall
   always_ff @(posedge clock) begin
      rk_ff[1] <= next_key({key_high_ff, key_low_ff}, 4'd1);
      for (int r = 2; r <= NumRounds; r++) begin
         rk_ff[r] <= next_key(rk_ff[r-1], 4'(r));
      end
   end

   // pipeline advances when the last stage is empty or taken
   assign adv = !vld_ff[NumRounds] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NumRounds-1:0], req_valid};
      end
   end

   // initial key add
   always_ff @(posedge clock) begin
      if (adv) begin
         st0_ff <= {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
      end
   end
   assign st[0] = st0_ff;

   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aes_round u_round (
         .clock   (clock),
         .enable  (adv),
         .mix_i   (r != NumRounds),
         .state_i (st[r-1]),
         .key_i   (rk_ff[r]),
         .state_o (st[r])
      );
   end

   assign rsp_valid       = vld_ff[NumRounds];
   assign rsp_cipher_high = st[NumRounds][127:64];
   assign rsp_cipher_low  = st[NumRounds][63:0];

   // a stalled word holds its ciphertext
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_high)
                                 && $stable(rsp_cipher_low))
      else $error("stalled word changed");
   // a word is taken only when the pipeline moves
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word lost");
   // ready follows the output stage
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("ready low with empty output");
endmodule
`default_nettype wire
